// File: rtl/csrmv_pkg.sv
// Shared constants, payload types and helper functions for the CSR sparse matrix-vector unit.
`timescale 1ns / 1ps

package csrmv_pkg;

  // Store sizes.
  localparam int MAX_ROWS     = 1024;
  localparam int MAX_NONZEROS = 8192;
  localparam int RS_DEPTH     = MAX_ROWS + 1;

  // Field widths.
  localparam int ROW_W  = 11;
  localparam int NZ_AW  = 13;
  localparam int COL_W  = 10;
  localparam int OFS_W  = 14;
  localparam int VAL_W  = 32;
  localparam int VEC_AW = 10;
  localparam int NZ_W   = COL_W + VAL_W;
  localparam int ACC_W  = VAL_W + NZ_AW + 1;

  // Configuration registers.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [ROW_W-1:0] ROW_COUNT_RST = ROW_W'(MAX_ROWS);
  localparam logic [VAL_W-1:0] SCALE_RST     = VAL_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 1'b0,
    CFG_SCALE     = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_NZ_WRITE  = 2'd0,
    REQ_RS_WRITE  = 2'd1,
    REQ_VEC_WRITE = 2'd2,
    REQ_COMPUTE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_END,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [NZ_AW-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic [COL_W-1:0]        entry_column;
    logic [ROW_W-1:0]        row_number;
    logic [OFS_W-1:0]        row_offset;
    logic [VEC_AW-1:0]       vec_index;
    logic signed [VAL_W-1:0] vec_value;
  } in_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]        result_row;
    logic signed [VAL_W-1:0] result_value;
    logic                    status;
  } out_beat_t;

  // Floor a Q32.32 product to Q16.16 and saturate to 32 bits.
  function automatic logic [VAL_W-1:0] sat_q16(input logic signed [2*VAL_W-1:0] p);
    logic signed [2*VAL_W-1:0] sh;
    sh = p >>> 16;
    if (&sh[2*VAL_W-1:VAL_W-1] || ~|sh[2*VAL_W-1:VAL_W-1]) begin
      return sh[VAL_W-1:0];
    end else if (sh[2*VAL_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

  // Saturate the wide accumulator to 32 bits.
  function automatic logic [VAL_W-1:0] sat_acc(input logic signed [ACC_W-1:0] a);
    if (&a[ACC_W-1:VAL_W-1] || ~|a[ACC_W-1:VAL_W-1]) begin
      return a[VAL_W-1:0];
    end else if (a[ACC_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/csr_sparse_matvec_unit.sv
// Top level of the CSR sparse matrix-vector unit: control, stores and the scaled MAC pipeline.
// Load beats are written at acceptance and give no result; one item is in work at a time.
// A compute row with N > 0 nonzeros loads its result after two start reads, one nonzero issued
// per cycle, five pipeline stages and a drain; an empty row does the start reads only, and an
// out-of-range row skips them. The next beat is taken the cycle after the load; a stalled out_ready waits.
// Reset sets row_count to 1024 and scale_factor to 1.0; the stores are undefined until written.
`timescale 1ns / 1ps

module csr_sparse_matvec_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  csrmv_pkg::in_beat_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output csrmv_pkg::out_beat_t                out_data,
  input  logic                                cfg_we,
  input  logic [csrmv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csrmv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int ROW_W  = csrmv_pkg::ROW_W;
  localparam int OFS_W  = csrmv_pkg::OFS_W;
  localparam int VAL_W  = csrmv_pkg::VAL_W;
  localparam int COL_W  = csrmv_pkg::COL_W;
  localparam int NZ_AW  = csrmv_pkg::NZ_AW;
  localparam int VEC_AW = csrmv_pkg::VEC_AW;
  localparam int ACC_W  = csrmv_pkg::ACC_W;
  localparam int NZ_W   = csrmv_pkg::NZ_W;

  // Configuration registers.
  logic [ROW_W-1:0] row_count_r;
  logic [VAL_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= csrmv_pkg::ROW_COUNT_RST;
      scale_r     <= csrmv_pkg::SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        csrmv_pkg::CFG_ROW_COUNT: row_count_r <= cfg_wdata[ROW_W-1:0];
        csrmv_pkg::CFG_SCALE:     scale_r     <= cfg_wdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  csrmv_pkg::state_t state_r, state_nxt;
  logic [ROW_W-1:0] row_r;
  logic             err_r;
  logic [OFS_W-1:0] k_r, end_r;
  logic             v1_r, v2_r, v3_r, v4_r, v5_r;
  logic             out_valid_r;
  csrmv_pkg::out_beat_t out_data_r;

  logic in_acc;
  logic is_compute;
  logic row_bad;
  logic issue;
  logic pipe_empty;
  logic out_load;
  logic [ROW_W-1:0] rs_raddr;

  // Memory read data.
  logic [OFS_W-1:0] rs_rdata;
  logic [NZ_W-1:0]  nz_rdata;
  logic [VAL_W-1:0] vec_rdata;
  logic [OFS_W-1:0] end_clamped;

  assign in_ready   = (state_r == csrmv_pkg::ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign is_compute = (in_data.req_type == csrmv_pkg::REQ_COMPUTE);
  assign row_bad    = (in_data.row_number >= row_count_r) ||
                      (in_data.row_number >= ROW_W'(csrmv_pkg::MAX_ROWS));
  assign issue      = (state_r == csrmv_pkg::ST_WALK) && (k_r < end_r);
  assign pipe_empty = !(v1_r || v2_r || v3_r || v4_r || v5_r);
  assign out_load   = (state_r == csrmv_pkg::ST_DONE) && (!out_valid_r || out_ready);
  assign end_clamped = (rs_rdata > OFS_W'(csrmv_pkg::MAX_NONZEROS)) ?
                       OFS_W'(csrmv_pkg::MAX_NONZEROS) : rs_rdata;

  // Next state and row-start read address.
  always_comb begin
    state_nxt = state_r;
    rs_raddr  = row_r + ROW_W'(1);
    case (state_r)
      csrmv_pkg::ST_IDLE: begin
        rs_raddr = in_data.row_number;
        if (in_acc && is_compute) begin
          state_nxt = row_bad ? csrmv_pkg::ST_DONE : csrmv_pkg::ST_BEGIN;
        end
      end
      csrmv_pkg::ST_BEGIN: begin
        state_nxt = csrmv_pkg::ST_END;
      end
      csrmv_pkg::ST_END: begin
        state_nxt = csrmv_pkg::ST_WALK;
      end
      csrmv_pkg::ST_WALK: begin
        if (!issue && pipe_empty) begin
          state_nxt = csrmv_pkg::ST_DONE;
        end
      end
      csrmv_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = csrmv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = csrmv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csrmv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Stores, written by load beats at acceptance.
  logic nz_we, rs_we, vec_we;
  assign nz_we  = in_acc && (in_data.req_type == csrmv_pkg::REQ_NZ_WRITE);
  assign rs_we  = in_acc && (in_data.req_type == csrmv_pkg::REQ_RS_WRITE) &&
                  (in_data.row_number <= ROW_W'(csrmv_pkg::MAX_ROWS));
  assign vec_we = in_acc && (in_data.req_type == csrmv_pkg::REQ_VEC_WRITE);

  csrmv_ram #(.WIDTH(NZ_W), .DEPTH(csrmv_pkg::MAX_NONZEROS), .AW(NZ_AW)) u_nz_ram (
    .clk   (clk),
    .we    (nz_we),
    .waddr (in_data.entry_index),
    .wdata ({in_data.entry_column, in_data.entry_value}),
    .raddr (k_r[NZ_AW-1:0]),
    .rdata (nz_rdata)
  );

  csrmv_ram #(.WIDTH(OFS_W), .DEPTH(csrmv_pkg::RS_DEPTH), .AW(ROW_W)) u_rs_ram (
    .clk   (clk),
    .we    (rs_we),
    .waddr (in_data.row_number),
    .wdata (in_data.row_offset),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  csrmv_ram #(.WIDTH(VAL_W), .DEPTH(csrmv_pkg::MAX_ROWS), .AW(VEC_AW)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (in_data.vec_index),
    .wdata (in_data.vec_value),
    .raddr (nz_rdata[NZ_W-1 -: COL_W]),
    .rdata (vec_rdata)
  );

  // Row bookkeeping and the walk counter.
  always_ff @(posedge clk) begin
    if (in_acc && is_compute) begin
      row_r <= in_data.row_number;
      err_r <= row_bad;
    end
    if (state_r == csrmv_pkg::ST_BEGIN) begin
      k_r <= rs_rdata;
    end else if (issue) begin
      k_r <= k_r + OFS_W'(1);
    end
    if (state_r == csrmv_pkg::ST_END) begin
      end_r <= end_clamped;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // MAC datapath: value times vector, floor and saturate, times scale, floor and saturate, accumulate.
  logic signed [VAL_W-1:0]   val_d_r;
  logic signed [2*VAL_W-1:0] prod1_r;
  logic signed [VAL_W-1:0]   p1_r;
  logic signed [2*VAL_W-1:0] prod2_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [VAL_W-1:0]   vec_s;
  logic signed [VAL_W-1:0]   scale_s;
  logic signed [VAL_W-1:0]   term;

  assign vec_s   = vec_rdata;
  assign scale_s = scale_r;
  assign term    = csrmv_pkg::sat_q16(prod2_r);

  always_ff @(posedge clk) begin
    val_d_r <= nz_rdata[VAL_W-1:0];
    prod1_r <= val_d_r * vec_s;
    p1_r    <= csrmv_pkg::sat_q16(prod1_r);
    prod2_r <= p1_r * scale_s;
    if (in_acc && is_compute) begin
      acc_r <= '0;
    end else if (v5_r) begin
      acc_r <= acc_r + ACC_W'(term);
    end
  end

  // Output register, parted from the compute side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.result_row   <= row_r;
      out_data_r.result_value <= err_r ? '0 : csrmv_pkg::sat_acc(acc_r);
      out_data_r.status       <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/csrmv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module csrmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
